FILE: hw/rtl/hafc_pkg.sv
// Shared types and constants for the HEVC Annex B frame classifier.
package hafc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TYPE_W = 6;
    localparam int unsigned TID_W  = 2;
    localparam int unsigned CLASS_W = 2;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;
    localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;
    localparam logic [1:0] ZERO_RUN_MAX = 2'd2;
    localparam logic [2:0] TID_MASK_MAX = 3'd3;

    localparam logic [TYPE_W-1:0] TYPE_TRAIL_N   = 6'd0;
    localparam logic [TYPE_W-1:0] TYPE_IRAP_LO   = 6'd16;
    localparam logic [TYPE_W-1:0] TYPE_IRAP_HI   = 6'd23;
    localparam logic [TYPE_W-1:0] TYPE_PARAM_LO  = 6'd32;
    localparam logic [TYPE_W-1:0] TYPE_PARAM_HI  = 6'd34;

    localparam logic [CLASS_W-1:0] CLASS_BASE    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_NONREF  = 2'd3;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_HDR0   = 2'd1,
        PH_HDR1   = 2'd2
    } t_phase;

    typedef struct packed {
        logic              valid;
        logic [TYPE_W-1:0] nal_type;
        logic [TID_W-1:0]  tid_sat;
    } t_hdr_evt;

    typedef struct packed {
        logic               valid;
        logic [CLASS_W-1:0] frame_class;
        logic               is_trail_n;
    } t_result;

endpackage

FILE: hw/rtl/hevc_annexb_frame_classifier.sv
// Top level of the HEVC Annex B frame classifier with its result register.
//
// The slave stream carries one byte of an Annex B frame per transaction,
// with tlast on the final byte of the frame. The block scans for 00 00 01
// start codes, reads each complete two-byte NAL header and gives one
// result transaction on the master stream per frame.
// Throughput is one byte per cycle while o_s_axis_tready is high; the per-byte work is a few
// compares and a register update between the byte and the result register.
// The result appears on the master side in the cycle after the transaction
// that carried tlast.
// The result register decouples the two sides: a ready receiver takes the
// held result in the same cycle as the next byte arrives, and only when a
// result is held and the receiver stalls does o_s_axis_tready drop, so no
// result is lost or overwritten.
// Synchronous reset clears the scan and frame state and empties the result
// register; the scan and frame state also clear after each frame.
module hevc_annexb_frame_classifier (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [hafc_pkg::BYTE_W-1:0]      i_s_axis_tdata,  // [7:0] data_byte
    input  logic                             i_s_axis_tlast,  // last_byte
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [hafc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata   // [1:0] frame_class, [2] is_trail_n
);

    logic                          w_accept;
    hafc_pkg::t_hdr_evt            w_evt;
    hafc_pkg::t_result             w_result;
    logic                          r_out_valid;
    logic [hafc_pkg::CLASS_W-1:0]  r_out_class;
    logic                          r_out_trail;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    hafc_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_evt    (w_evt)
    );

    hafc_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_last   (i_s_axis_tlast),
        .i_evt    (w_evt),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.valid) begin
            r_out_class <= w_result.frame_class;
            r_out_trail <= w_result.is_trail_n;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(hafc_pkg::OUT_DATA_W - hafc_pkg::CLASS_W - 1){1'b0}},
                              r_out_trail, r_out_class};

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while a result is stalled");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tlast) |=> o_m_axis_tvalid)
        else $error("no result after the final byte of a frame");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_accept && i_s_axis_tlast))
        else $error("result appeared without a final byte");

endmodule

FILE: hw/rtl/hafc_scan.sv
// Start code search and two-byte NAL header capture.
module hafc_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [hafc_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_last,
    output hafc_pkg::t_hdr_evt            o_evt
);

    hafc_pkg::t_phase              r_phase;
    hafc_pkg::t_phase              n_phase;
    logic [1:0]                    r_zero_run;
    logic [1:0]                    n_zero_run;
    logic [hafc_pkg::TYPE_W-1:0]   r_pending_type;
    logic [hafc_pkg::TYPE_W-1:0]   n_pending_type;
    hafc_pkg::t_phase              w_phase_mid;
    logic [2:0]                    w_tid3;

    always_comb begin
        w_phase_mid = r_phase;
        unique case (r_phase)
            hafc_pkg::PH_SEARCH: w_phase_mid = hafc_pkg::PH_SEARCH;
            hafc_pkg::PH_HDR0:   w_phase_mid = hafc_pkg::PH_HDR1;
            hafc_pkg::PH_HDR1:   w_phase_mid = hafc_pkg::PH_SEARCH;
            default:             w_phase_mid = hafc_pkg::PH_SEARCH;
        endcase
        n_phase = w_phase_mid;
        if (i_byte == hafc_pkg::START_BYTE && r_zero_run >= hafc_pkg::ZERO_RUN_MAX &&
            w_phase_mid == hafc_pkg::PH_SEARCH) begin
            n_phase = hafc_pkg::PH_HDR0;
        end
        if (i_last) begin
            n_phase = hafc_pkg::PH_SEARCH;
        end
    end

    always_comb begin
        n_pending_type = r_pending_type;
        if (r_phase == hafc_pkg::PH_HDR0) begin
            n_pending_type = i_byte[hafc_pkg::TYPE_W:1];
        end
        if (i_last) begin
            n_pending_type = '0;
        end
        if (i_byte == hafc_pkg::ZERO_BYTE) begin
            n_zero_run = (r_zero_run < hafc_pkg::ZERO_RUN_MAX) ? r_zero_run + 2'd1 : r_zero_run;
        end else begin
            n_zero_run = '0;
        end
        if (i_last) begin
            n_zero_run = '0;
        end
    end

    always_comb begin
        w_tid3 = i_byte[2:0];
        o_evt.valid    = i_accept && (r_phase == hafc_pkg::PH_HDR1);
        o_evt.nal_type = r_pending_type;
        if (w_tid3 >= hafc_pkg::TID_MASK_MAX) begin
            o_evt.tid_sat = 2'd2;
        end else if (w_tid3 == 3'd2) begin
            o_evt.tid_sat = 2'd1;
        end else begin
            o_evt.tid_sat = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= hafc_pkg::PH_SEARCH;
            r_zero_run     <= '0;
            r_pending_type <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_zero_run     <= n_zero_run;
            r_pending_type <= n_pending_type;
        end
    end

endmodule

FILE: hw/rtl/hafc_accum.sv
// Per-frame accumulation of class and trail flag from NAL header events.
module hafc_accum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_last,
    input  hafc_pkg::t_hdr_evt  i_evt,
    output hafc_pkg::t_result   o_result
);

    logic                          r_class_found;
    logic                          n_class_found;
    logic [hafc_pkg::CLASS_W-1:0]  r_class_value;
    logic [hafc_pkg::CLASS_W-1:0]  n_class_value;
    logic                          r_critical_seen;
    logic                          n_critical_seen;
    logic                          r_trail_decided;
    logic                          n_trail_decided;
    logic                          r_trail_value;
    logic                          n_trail_value;
    logic                          w_critical;
    logic                          w_slice;
    logic                          w_trail_n;

    always_comb begin
        w_critical = (i_evt.nal_type >= hafc_pkg::TYPE_IRAP_LO &&
                      i_evt.nal_type <= hafc_pkg::TYPE_IRAP_HI) ||
                     (i_evt.nal_type >= hafc_pkg::TYPE_PARAM_LO &&
                      i_evt.nal_type <= hafc_pkg::TYPE_PARAM_HI);
        w_slice   = i_evt.nal_type < hafc_pkg::TYPE_IRAP_LO;
        w_trail_n = i_evt.nal_type == hafc_pkg::TYPE_TRAIL_N;

        n_class_found   = r_class_found;
        n_class_value   = r_class_value;
        n_critical_seen = r_critical_seen;
        n_trail_decided = r_trail_decided;
        n_trail_value   = r_trail_value;

        if (i_evt.valid && w_critical) begin
            n_critical_seen = 1'b1;
            if (!r_trail_decided) begin
                n_trail_decided = 1'b1;
                n_trail_value   = 1'b0;
            end
        end else if (i_evt.valid && w_slice) begin
            if (!r_class_found) begin
                n_class_found = 1'b1;
                n_class_value = w_trail_n ? hafc_pkg::CLASS_NONREF : i_evt.tid_sat + 2'd1;
            end
            if (!r_trail_decided) begin
                n_trail_decided = 1'b1;
                n_trail_value   = w_trail_n;
            end
        end

        o_result.valid       = i_accept && i_last;
        o_result.frame_class = (n_critical_seen || !n_class_found) ?
                               hafc_pkg::CLASS_BASE : n_class_value;
        o_result.is_trail_n  = n_trail_decided && n_trail_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_found   <= 1'b0;
            r_class_value   <= '0;
            r_critical_seen <= 1'b0;
            r_trail_decided <= 1'b0;
            r_trail_value   <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_class_found   <= 1'b0;
                r_class_value   <= '0;
                r_critical_seen <= 1'b0;
                r_trail_decided <= 1'b0;
                r_trail_value   <= 1'b0;
            end else begin
                r_class_found   <= n_class_found;
                r_class_value   <= n_class_value;
                r_critical_seen <= n_critical_seen;
                r_trail_decided <= n_trail_decided;
                r_trail_value   <= n_trail_value;
            end
        end
    end

endmodule

FILE: tb/annexb_frame_class_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the class and trail flag of each Annex B frame and compares results.
module annexb_frame_class_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [hafc_pkg::BYTE_W-1:0]     i_s_tdata,      // [7:0] data_byte
    input  logic                            i_s_tlast,      // last_byte
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [hafc_pkg::OUT_DATA_W-1:0] i_m_tdata,      // [1:0] frame_class, [2] is_trail_n
    output int                              o_fail_count,
    output int                              o_pending
);

    typedef struct packed {
        logic [hafc_pkg::CLASS_W-1:0] frame_class;
        logic                         is_trail_n;
    } t_frame_verdict;

    t_frame_verdict verdict_q[$];
    int             errors;

    logic [1:0]                   zero_cnt;
    hafc_pkg::t_phase             phase;
    logic [hafc_pkg::TYPE_W-1:0]  held_type;
    logic                         slice_seen;
    logic [hafc_pkg::CLASS_W-1:0] slice_class;
    logic                         crit_seen;
    logic                         first_decided;
    logic                         first_is_trail_n;

    task automatic clear_frame();
        zero_cnt         = '0;
        phase            = hafc_pkg::PH_SEARCH;
        held_type        = '0;
        slice_seen       = 1'b0;
        slice_class      = '0;
        crit_seen        = 1'b0;
        first_decided    = 1'b0;
        first_is_trail_n = 1'b0;
    endtask

    task automatic absorb_header(input logic [hafc_pkg::TYPE_W-1:0] nal_type,
                                 input logic [7:0] hdr1);
        logic [2:0] tid;
        logic       crit;
        tid  = (hdr1[2:0] == 3'd0) ? 3'd0 : hdr1[2:0] - 3'd1;
        crit = (nal_type >= hafc_pkg::TYPE_IRAP_LO && nal_type <= hafc_pkg::TYPE_IRAP_HI) ||
               (nal_type >= hafc_pkg::TYPE_PARAM_LO && nal_type <= hafc_pkg::TYPE_PARAM_HI);
        if (crit) begin
            crit_seen = 1'b1;
            if (!first_decided) begin
                first_decided    = 1'b1;
                first_is_trail_n = 1'b0;
            end
        end else if (nal_type < hafc_pkg::TYPE_IRAP_LO) begin
            if (!slice_seen) begin
                slice_seen = 1'b1;
                if (nal_type == hafc_pkg::TYPE_TRAIL_N)
                    slice_class = hafc_pkg::CLASS_NONREF;
                else if (tid >= 3'd2)
                    slice_class = 2'd3;
                else
                    slice_class = tid[1:0] + 2'd1;
            end
            if (!first_decided) begin
                first_decided    = 1'b1;
                first_is_trail_n = (nal_type == hafc_pkg::TYPE_TRAIL_N);
            end
        end
    endtask

    task automatic absorb_byte(input logic [hafc_pkg::BYTE_W-1:0] b, input logic is_last);
        t_frame_verdict v;
        if (phase == hafc_pkg::PH_HDR0) begin
            held_type = b[6:1];
            phase     = hafc_pkg::PH_HDR1;
        end else if (phase == hafc_pkg::PH_HDR1) begin
            absorb_header(held_type, b);
            phase = hafc_pkg::PH_SEARCH;
        end
        if (b == hafc_pkg::START_BYTE && zero_cnt >= hafc_pkg::ZERO_RUN_MAX &&
            phase == hafc_pkg::PH_SEARCH)
            phase = hafc_pkg::PH_HDR0;
        if (b == hafc_pkg::ZERO_BYTE) begin
            if (zero_cnt < hafc_pkg::ZERO_RUN_MAX)
                zero_cnt = zero_cnt + 2'd1;
        end else begin
            zero_cnt = '0;
        end
        if (is_last) begin
            v.frame_class = (crit_seen || !slice_seen) ? hafc_pkg::CLASS_BASE : slice_class;
            v.is_trail_n  = first_decided && first_is_trail_n;
            verdict_q.push_back(v);
            clear_frame();
        end
    endtask

    initial begin
        errors = 0;
        clear_frame();
    end

    always @(posedge i_clk) begin
        t_frame_verdict want;
        if (!i_rst_n) begin
            clear_frame();
            verdict_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("result transaction with no frame pending: tdata %02h", i_m_tdata);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_m_tdata[1:0] !== want.frame_class) begin
                        $error("frame_class mismatch: expected %0d, actual %0d",
                               want.frame_class, i_m_tdata[1:0]);
                        errors++;
                    end
                    if (i_m_tdata[2] !== want.is_trail_n) begin
                        $error("is_trail_n mismatch: expected %0d, actual %0d",
                               want.is_trail_n, i_m_tdata[2]);
                        errors++;
                    end
                    if (i_m_tdata[hafc_pkg::OUT_DATA_W-1:3] !== '0) begin
                        $error("tdata padding mismatch: expected 0, actual %0h",
                               i_m_tdata[hafc_pkg::OUT_DATA_W-1:3]);
                        errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                absorb_byte(i_s_tdata, i_s_tlast);
        end
        o_fail_count <= errors;
        o_pending    <= verdict_q.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the frame classifier test: clock, reset, byte stream stimulus and verdict.
module testbench;

    localparam int RANDOM_BYTES  = 750;
    localparam int QUIET_FROM    = 640;
    localparam int WATCHDOG_MAX  = 2000;

    logic                            i_clk;
    logic                            i_rst_n  = 1'b0;
    logic                            s_valid  = 1'b0;
    logic [hafc_pkg::BYTE_W-1:0]     s_data   = '0;
    logic                            s_last   = 1'b0;
    logic                            s_ready;
    logic                            m_valid;
    logic                            m_ready  = 1'b0;
    logic [hafc_pkg::OUT_DATA_W-1:0] m_data;
    int                              fail_count;
    int                              pending;

    logic                            quiet    = 1'b0;
    int                              sent_bytes = 0;
    logic [hafc_pkg::BYTE_W-1:0]     frame_buf[$];
    int                              idle_cycles = 0;

    hevc_annexb_frame_classifier uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    annexb_frame_class_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tlast    (s_last),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver alternates between ready stretches and stall bursts, and stays ready once quiet is set.
    always @(posedge i_clk) begin
        int rx_left;
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (rx_left > 0) begin
            rx_left--;
        end else if ($urandom_range(0, 2) == 0) begin
            m_ready <= 1'b0;
            rx_left = $urandom_range(1, 10) - 1;
        end else begin
            m_ready <= 1'b1;
            rx_left = $urandom_range(1, 20) - 1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("hevc_annexb_frame_classifier test failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [hafc_pkg::BYTE_W-1:0] b, input logic is_last);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= is_last;
        do @(posedge i_clk); while (!s_ready);
        sent_bytes++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [hafc_pkg::TYPE_W-1:0] pick_nal_type();
        case ($urandom_range(0, 5))
            0:       return hafc_pkg::TYPE_TRAIL_N;
            1, 2:    return 6'($urandom_range(1, hafc_pkg::TYPE_IRAP_LO - 1));
            3:       return 6'($urandom_range(hafc_pkg::TYPE_IRAP_LO, hafc_pkg::TYPE_IRAP_HI));
            4:       return 6'($urandom_range(hafc_pkg::TYPE_PARAM_LO, hafc_pkg::TYPE_PARAM_HI));
            default: begin
                if ($urandom_range(0, 1) == 0)
                    return 6'($urandom_range(hafc_pkg::TYPE_IRAP_HI + 1,
                                             hafc_pkg::TYPE_PARAM_LO - 1));
                return 6'($urandom_range(hafc_pkg::TYPE_PARAM_HI + 1, 63));
            end
        endcase
    endfunction

    function automatic logic [hafc_pkg::BYTE_W-1:0] pick_filler();
        case ($urandom_range(0, 7))
            0, 1:    return hafc_pkg::ZERO_BYTE;
            2:       return hafc_pkg::START_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic build_nal_frame();
        int                          n_nal;
        int                          cut;
        logic [hafc_pkg::BYTE_W-1:0] hdr0;
        frame_buf = {};
        n_nal = $urandom_range(1, 4);
        repeat (n_nal) begin
            if ($urandom_range(0, 2) == 0)
                frame_buf.push_back(hafc_pkg::ZERO_BYTE);
            frame_buf.push_back(hafc_pkg::ZERO_BYTE);
            frame_buf.push_back(hafc_pkg::ZERO_BYTE);
            frame_buf.push_back(hafc_pkg::START_BYTE);
            hdr0 = 8'($urandom);
            hdr0[6:1] = pick_nal_type();
            frame_buf.push_back(hdr0);
            frame_buf.push_back(8'($urandom));
            repeat ($urandom_range(0, 6)) frame_buf.push_back(pick_filler());
        end
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, frame_buf.size());
            while (frame_buf.size() > cut) void'(frame_buf.pop_back());
        end
    endtask

    task automatic build_noise_frame();
        frame_buf = {};
        repeat ($urandom_range(1, 8)) frame_buf.push_back(pick_filler());
    endtask

    initial begin
        logic paused;
        paused = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        frame_buf = {8'hFF};
        send_frame();
        frame_buf = {hafc_pkg::ZERO_BYTE, hafc_pkg::ZERO_BYTE, hafc_pkg::START_BYTE,
                     8'h00, 8'h01};
        send_frame();
        frame_buf = {hafc_pkg::ZERO_BYTE, hafc_pkg::ZERO_BYTE, hafc_pkg::START_BYTE,
                     8'h02, 8'h07};
        send_frame();
        frame_buf = {hafc_pkg::ZERO_BYTE, hafc_pkg::ZERO_BYTE, hafc_pkg::START_BYTE,
                     8'h26, 8'h01};
        send_frame();
        frame_buf = {hafc_pkg::ZERO_BYTE, hafc_pkg::ZERO_BYTE, hafc_pkg::START_BYTE, 8'h7E};
        send_frame();
        frame_buf = {hafc_pkg::ZERO_BYTE, hafc_pkg::ZERO_BYTE, hafc_pkg::START_BYTE};
        send_frame();
        drain();

        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            if (!paused && sent_bytes >= RANDOM_BYTES / 2) begin
                drain();
                paused = 1'b1;
            end
            if (sent_bytes >= QUIET_FROM)
                quiet <= 1'b1;
            if ($urandom_range(0, 6) == 0)
                build_noise_frame();
            else
                build_nal_frame();
            send_frame();
        end
        drain();
        repeat (5) @(posedge i_clk);

        if (fail_count == 0)
            $display("hevc_annexb_frame_classifier test passed");
        else
            $display("hevc_annexb_frame_classifier test failed");
        $finish;
    end

endmodule
